// File: rtl/core/m4rt_pkg.sv
package m4rt_pkg;

   localparam int ELEM_W = 32;
   localparam int ROW_W  = 2;
   localparam int LANES  = 4;
   localparam int DATA_W = 136;
   localparam int USER_W = 1;

   typedef enum logic {
      OP_LOAD      = 1'b0,
      OP_TRANSFORM = 1'b1
   } m4rt_op_type;

   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] row;
   } m4rt_stage_type;

endpackage

// File: rtl/core/mat4_row_transform.sv
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tuser: operation; tdata: row_index, elem_0..elem_3
// rsp      out  rsp_tvalid/rsp_tready  tdata: out_row, out_0..out_3
//
// One request per cycle while rsp is not stalled. A transform is registered after the
// sixteen lane multipliers, then after the lane adders/saturation in the output register.
// A load writes its matrix row at the accepting edge and gives no response.
// Reset clears the matrix to zero and empties the pipeline.
// A stalled rsp holds the output register; req stalls once the product stage is full too.
module mat4_row_transform #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [129:98] elem_3, [97:66] elem_2, [65:34] elem_1, [33:2] elem_0, [1:0] row_index
   input  logic [m4rt_pkg::DATA_W-1:0] req_tdata,
   // [0] operation
   input  logic [m4rt_pkg::USER_W-1:0] req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [129:98] out_3, [97:66] out_2, [65:34] out_1, [33:2] out_0, [1:0] out_row
   output logic [m4rt_pkg::DATA_W-1:0] rsp_tdata
);
   import m4rt_pkg::*;

   logic signed [WORD_BITS-1:0] elem [LANES];
   logic signed [WORD_BITS-1:0] matrix_in [LANES*LANES];
   logic signed [WORD_BITS-1:0] matrix_ff [LANES*LANES];
   logic signed [WORD_BITS-1:0] column [LANES][LANES];
   logic signed [WORD_BITS-1:0] result [LANES];
   logic [ROW_W-1:0]            req_row;
   m4rt_op_type                 req_op;
   logic                        req_accept;
   logic                        s1_ready;
   logic                        merge_ready;
   m4rt_stage_type              s1_in, s1_ff;

   assign req_row    = req_tdata[ROW_W-1:0];
   assign req_op     = m4rt_op_type'(req_tuser[0]);
   assign s1_ready   = !s1_ff.valid || merge_ready;
   assign req_tready = s1_ready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         elem[k] = req_tdata[ROW_W + k*ELEM_W +: WORD_BITS];
      end
   end

   always_comb begin
      matrix_in = matrix_ff;
      if (req_accept && req_op == OP_LOAD) begin
         for (int k = 0; k < LANES; k++) begin
            matrix_in[{req_row, 2'(k)}] = elem[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES*LANES; i++) begin
            matrix_ff[i] <= '0;
         end
      end else begin
         matrix_ff <= matrix_in;
      end
   end

   always_comb begin
      s1_in = s1_ff;
      if (s1_ready) begin
         s1_in.valid = req_accept && req_op == OP_TRANSFORM;
         s1_in.row   = req_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   // lane j owns column j of the stored matrix
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         for (int k = 0; k < LANES; k++) begin
            column[j][k] = matrix_ff[k*LANES + j];
         end
      end
   end

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      m4rt_lane #(
         .WORD_BITS(WORD_BITS),
         .FRAC_BITS(FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .load  (s1_ready),
         .elem  (elem),
         .column(column[j]),
         .result(result[j])
      );
   end

   m4rt_merge #(
      .WORD_BITS(WORD_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .stage     (s1_ff),
      .result    (result),
      .ready     (merge_ready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

`ifndef SYNTH
   a_transform_enters: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op == OP_TRANSFORM)
      |=> (s1_ff.valid && s1_ff.row == $past(req_row)))
      else $error("transform request did not enter product stage");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.valid && !merge_ready) |=> (s1_ff.valid && $stable(s1_ff.row)))
      else $error("product stage lost a stalled request");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");
`endif

endmodule

// File: rtl/core/m4rt_lane.sv
module m4rt_lane #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic signed [WORD_BITS-1:0] elem [4],
   input  logic signed [WORD_BITS-1:0] column [4],
   output logic signed [WORD_BITS-1:0] result
);
   import m4rt_pkg::*;

   localparam int PROD_W  = 2 * WORD_BITS;
   localparam int SHIFT_W = PROD_W - FRAC_BITS;
   localparam int SUM_W   = SHIFT_W + 2;

   logic signed [PROD_W-1:0] prod_in [LANES];
   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic signed [SUM_W-1:0]  sum;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         prod_in[k] = elem[k] * column[k];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // floor shift of each product, exact sum, one saturation
   always_comb begin
      sum = '0;
      for (int k = 0; k < LANES; k++) begin
         sum = sum + SUM_W'($signed(prod_ff[k][PROD_W-1:FRAC_BITS]));
      end
      if (sum[SUM_W-1:WORD_BITS-1] == {(SUM_W-WORD_BITS+1){sum[SUM_W-1]}}) begin
         result = sum[WORD_BITS-1:0];
      end else if (sum[SUM_W-1]) begin
         result = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         result = {1'b0, {(WORD_BITS-1){1'b1}}};
      end
   end

endmodule

// File: rtl/core/m4rt_merge.sv
module m4rt_merge #(
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  m4rt_pkg::m4rt_stage_type    stage,
   input  logic signed [WORD_BITS-1:0] result [4],
   output logic                        ready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [m4rt_pkg::DATA_W-1:0] rsp_tdata
);
   import m4rt_pkg::*;

   logic              valid_in, valid_ff;
   logic [DATA_W-1:0] data_in, data_ff;

   assign ready = !valid_ff || rsp_tready;

   always_comb begin
      data_in = '0;
      data_in[ROW_W-1:0] = stage.row;
      for (int j = 0; j < LANES; j++) begin
         data_in[ROW_W + j*ELEM_W +: ELEM_W] = ELEM_W'(result[j]);
      end
      if (ready) begin
         valid_in = stage.valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && stage.valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import m4rt_pkg::*;

   localparam int FRAC_BITS   = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam logic [31:0] ONE_Q   = 32'h0001_0000;
   localparam logic [31:0] MAX_Q   = 32'h7fff_ffff;
   localparam logic [31:0] MIN_Q   = 32'h8000_0000;
   localparam logic [31:0] NEG_ONE = 32'hffff_ffff;

   typedef struct packed {
      logic [1:0]       row;
      logic [3:0][31:0] elem;
   } row_result_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata  = '0;
   logic [USER_W-1:0]   req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [DATA_W-1:0]   rsp_tdata;

   logic [31:0]         left_rows [4][4];
   row_result_type      pending_results [$];
   int                  mismatches  = 0;
   int                  quiet_count = 0;
   int                  hold_left   = 0;
   int                  stall_left  = 0;
   bit                  req_idle_on = 1'b0;
   bit                  rsp_idle_on = 1'b0;

   mat4_row_transform dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] pick_elem();
      int unsigned r;
      logic [31:0] corner [7];
      corner = '{32'h0, 32'h1, NEG_ONE, MAX_Q, MIN_Q, ONE_Q, 32'hffff_0000};
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom;
      if (r < 70) return $urandom_range(0, 32'h3ffff) - 32'h20000;
      if (r < 90) return $urandom_range(0, 32'h1ff_ffff) - 32'h100_0000;
      return corner[$urandom_range(0, 6)];
   endfunction

   // out_j = sum_k floor(e_k * L[k][j] / 2^FRAC_BITS), saturated to 32 bits
   function automatic logic [31:0] column_dot(logic [3:0][31:0] e, int j);
      longint acc;
      longint prod;
      acc = 0;
      for (int k = 0; k < 4; k++) begin
         prod = longint'($signed(e[k])) * longint'($signed(left_rows[k][j]));
         acc += prod >>> FRAC_BITS;
      end
      if (acc > longint'(32'sh7fff_ffff)) return MAX_Q;
      if (acc < -longint'(32'sh7fff_ffff) - 1) return MIN_Q;
      return acc[31:0];
   endfunction

   function automatic void predict_request(m4rt_op_type op, logic [1:0] row,
                                           logic [3:0][31:0] e);
      row_result_type res;
      if (op == OP_LOAD) begin
         for (int k = 0; k < 4; k++) left_rows[row][k] = e[k];
      end else begin
         res.row = row;
         for (int j = 0; j < 4; j++) res.elem[j] = column_dot(e, j);
         pending_results.push_back(res);
      end
   endfunction

   task automatic send_request(m4rt_op_type op, logic [1:0] row, logic [3:0][31:0] e);
      int gap;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, e, row};
      do @(posedge clock); while (!req_tready);
      predict_request(op, row, e);
   endtask

   task automatic send_random_request(int load_pct);
      logic [3:0][31:0] e;
      m4rt_op_type op;
      for (int k = 0; k < 4; k++) e[k] = pick_elem();
      op = ($urandom_range(0, 99) < load_pct) ? OP_LOAD : OP_TRANSFORM;
      send_request(op, 2'($urandom_range(0, 3)), e);
   endtask

   task automatic load_uniform_matrix(logic [31:0] v);
      for (int r = 0; r < 4; r++) send_request(OP_LOAD, 2'(r), {v, v, v, v});
   endtask

   task automatic check_cleared_matrix();
      for (int r = 0; r < 4; r++)
         send_request(OP_TRANSFORM, 2'(r), {MAX_Q, MIN_Q, 32'($urandom), NEG_ONE});
   endtask

   task automatic check_identity_pass_through();
      logic [3:0][31:0] row_v;
      for (int r = 0; r < 4; r++) begin
         row_v = '0;
         row_v[r] = ONE_Q;
         send_request(OP_LOAD, 2'(r), row_v);
      end
      send_request(OP_TRANSFORM, 2'd0, {MAX_Q, MIN_Q, 32'h0, NEG_ONE});
      send_request(OP_TRANSFORM, 2'd3, {32'h5555_5555, 32'haaaa_aaaa, ONE_Q, 32'h1});
   endtask

   task automatic check_saturation();
      load_uniform_matrix(MAX_Q);
      send_request(OP_TRANSFORM, 2'd1, {MAX_Q, MAX_Q, MAX_Q, MAX_Q});
      send_request(OP_TRANSFORM, 2'd2, {MIN_Q, MIN_Q, MIN_Q, MIN_Q});
      load_uniform_matrix(MIN_Q);
      send_request(OP_TRANSFORM, 2'd3, {MIN_Q, MIN_Q, MIN_Q, MIN_Q});
      send_request(OP_TRANSFORM, 2'd0, {MIN_Q, MAX_Q, MIN_Q, MAX_Q});
   endtask

   task automatic check_floor_rounding();
      send_request(OP_LOAD, 2'd0, {NEG_ONE, 32'h1, NEG_ONE, 32'h1});
      send_request(OP_TRANSFORM, 2'd2, {32'h0, 32'h0, 32'h0, 32'h1});
      send_request(OP_TRANSFORM, 2'd1, {32'h0, 32'h0, 32'h0, 32'hffff_0001});
   endtask

   // receiver holds off long enough for the block to fill up and stall requests
   task automatic check_output_stall();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_left   = 120;
      for (int i = 0; i < 40; i++) send_random_request(10);
   endtask

   task automatic check_random_stream();
      for (int phase = 0; phase < 12; phase++) begin
         req_idle_on = (phase % 3) != 0;
         rsp_idle_on = (phase % 4) != 1;
         for (int i = 0; i < 50; i++) send_random_request(25);
      end
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_idle_on && $urandom_range(0, 99) < 30) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      row_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("response with no transform pending: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] !== want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, rsp_tdata[1:0]);
               mismatches++;
            end
            for (int j = 0; j < 4; j++) begin
               if (rsp_tdata[2 + 32*j +: 32] !== want.elem[j]) begin
                  $error("out_%0d: expected %h, got %h", j, want.elem[j],
                         rsp_tdata[2 + 32*j +: 32]);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_count <= 0;
      end else begin
         quiet_count <= quiet_count + 1;
         if (quiet_count >= QUIET_LIMIT) begin
            $display("mat4_row_transform regression: fail");
            $finish;
         end
      end
   end

   initial begin
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) left_rows[r][c] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      check_cleared_matrix();
      check_identity_pass_through();
      check_saturation();
      check_floor_rounding();
      check_output_stall();
      check_random_stream();
      req_tvalid  <= 1'b0;
      rsp_idle_on = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("mat4_row_transform regression: pass");
      end else begin
         $display("mat4_row_transform regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/m4rt_pkg.sv
rtl/core/m4rt_lane.sv
rtl/core/m4rt_merge.sv
rtl/core/mat4_row_transform.sv
tb/sv/tb_top.sv
